/* rtl/core/tempo_map_tick_to_sample_defines.svh */
// Assertion macros shared by the tempo map design.
`ifndef TEMPO_MAP_TICK_TO_SAMPLE_DEFINES_SVH
`define TEMPO_MAP_TICK_TO_SAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
`define TMTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TMTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TMTS_ASSERT(lbl, prop)
`define TMTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/tmts_pkg.sv */
package tmts_pkg;

  localparam int MaxSegments = 16;
  localparam int SegIdxW     = 4;
  localparam int CountW      = 5;
  localparam int TickW       = 32;
  localparam int TempoW      = 24;
  localparam int ProdW       = TickW + TempoW;
  localparam int SumW        = ProdW + SegIdxW;
  localparam int TpbW        = 16;
  localparam int RateW       = 18;
  localparam int NumW        = SumW + RateW;
  localparam int UsecW       = 20;
  localparam int DenW        = TpbW + UsecW;
  localparam int DivCntW     = 7;
  localparam int MulCntW     = 5;
  localparam int TimeW       = 40;
  localparam int SampleW     = 32;

  localparam logic [UsecW-1:0] UsecPerSec = UsecW'(1000000);
  localparam logic [TpbW-1:0]  TpbReset   = TpbW'(480);
  localparam logic [RateW-1:0] RateReset  = RateW'(44100);

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_CONVERT = 1'b1
  } action_t;

  typedef enum logic {
    REG_TPB  = 1'b0,
    REG_RATE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  // Query token handed from cell to cell along the segment chain.
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [TickW-1:0] tick;
    logic [SumW-1:0]  acc;
    logic [ProdW-1:0] prod;
  } tok_t;

endpackage

/* rtl/core/tmts_seg_cell.sv */
module tmts_seg_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [tmts_pkg::TickW-1:0]  wr_start,
  input  logic [tmts_pkg::TempoW-1:0] wr_tempo,
  input  logic                      is_last,
  input  logic [tmts_pkg::TickW-1:0]  next_start,
  output logic [tmts_pkg::TickW-1:0]  start_out,
  input  tmts_pkg::tok_t            tok_in,
  output tmts_pkg::tok_t            tok_out
);

  logic [tmts_pkg::TickW-1:0]  seg_start;
  logic [tmts_pkg::TempoW-1:0] seg_tempo;
  logic [tmts_pkg::TickW-1:0]  span_end;
  logic [tmts_pkg::TickW-1:0]  span;
  logic                        ends_here;
  logic [tmts_pkg::ProdW-1:0]  prod_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_start <= wr_start;
      seg_tempo <= wr_tempo;
    end
  end

  assign start_out = seg_start;

  // The query ends in this segment when it is the last one or the next starts later.
  assign ends_here = is_last || (next_start > tok_in.tick);
  assign span_end  = ends_here ? tok_in.tick : next_start;
  assign span      = (span_end > seg_start) ? (span_end - seg_start) : '0;
  assign prod_next = tok_in.done ? '0 : (tmts_pkg::ProdW'(seg_tempo) * tmts_pkg::ProdW'(span));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.done <= tok_in.done || ends_here;
    tok_out.tick <= tok_in.tick;
    tok_out.acc  <= tok_in.acc + tmts_pkg::SumW'(tok_in.prod);
    tok_out.prod <= prod_next;
  end

endmodule

/* rtl/core/tmts_div.sv */
module tmts_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tmts_pkg::NumW-1:0]  num,
  input  logic [tmts_pkg::DenW-1:0]  den,
  output logic                       done,
  output logic [tmts_pkg::NumW-1:0]  quo
);

  localparam logic [tmts_pkg::DivCntW-1:0] LastStep = tmts_pkg::DivCntW'(tmts_pkg::NumW - 1);

  logic                            busy;
  logic [tmts_pkg::DivCntW-1:0]    cnt;
  logic [tmts_pkg::DenW-1:0]       dvs;
  logic [tmts_pkg::DenW:0]         rem;
  logic [tmts_pkg::DenW:0]         rem_sh;
  logic                            fits;

  // One quotient bit per cycle, restoring form; quo shifts the numerator out
  // at the top while quotient bits enter at the bottom.
  assign rem_sh = {rem[tmts_pkg::DenW-1:0], quo[tmts_pkg::NumW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LastStep);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LastStep)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[tmts_pkg::NumW-2:0], fits};
    end
  end

endmodule

/* rtl/core/tempo_map_tick_to_sample.sv */
// Timing: a load item is written into its segment cell at the edge that accepts it.
// A convert item passes through the launch register, the segment chain, the serial rate
// multiply, the two parallel serial dividers and then the output register.
// Flow: a convert is not taken until the previous result has entered the output register,
// which waits while out_stall holds the result; loads are taken back to back while idle.
// Reset (rst, synchronous) clears the segment count, chain and control, and restores
// ticks_per_beat 480, sample_rate 44100.
`include "tempo_map_tick_to_sample_defines.svh"

module tempo_map_tick_to_sample (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [tmts_pkg::SegIdxW-1:0]  segment_index,
  input  logic [tmts_pkg::TickW-1:0]    segment_start_tick,
  input  logic [tmts_pkg::TempoW-1:0]   segment_usec_per_beat,
  input  logic                          last_segment,
  input  logic [tmts_pkg::TickW-1:0]    query_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmts_pkg::TimeW-1:0]    time_usec,
  output logic [tmts_pkg::SampleW-1:0]  sample_offset,
  output logic                          saturated,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [tmts_pkg::RateW-1:0]    cfg_data
);

  localparam logic [tmts_pkg::MulCntW-1:0] MulLast = tmts_pkg::MulCntW'(tmts_pkg::RateW - 1);

  tmts_pkg::state_t state, state_next;

  logic [tmts_pkg::TpbW-1:0]    ticks_per_beat;
  logic [tmts_pkg::RateW-1:0]   sample_rate;
  logic [tmts_pkg::CountW-1:0]  seg_count;
  logic [tmts_pkg::TpbW-1:0]    tpb_eff;

  tmts_pkg::tok_t               tok_launch;
  tmts_pkg::tok_t               tok [tmts_pkg::MaxSegments+1];
  logic [tmts_pkg::TickW-1:0]   starts [tmts_pkg::MaxSegments];
  logic [tmts_pkg::MaxSegments-1:0] tok_valids;

  logic                         in_accept;
  logic                         load_acc;
  logic                         conv_acc;
  logic                         sum_load;
  logic                         div_start;
  logic                         out_load;

  logic [tmts_pkg::SumW-1:0]    sum;
  logic [tmts_pkg::NumW-1:0]    mcand;
  logic [tmts_pkg::RateW-1:0]   mplier;
  logic [tmts_pkg::NumW-1:0]    mprod;
  logic [tmts_pkg::NumW-1:0]    mprod_next;
  logic [tmts_pkg::MulCntW-1:0] mul_cnt;
  logic [tmts_pkg::DenW-1:0]    den;

  logic                         tdiv_done;
  logic                         sdiv_done;
  logic [tmts_pkg::NumW-1:0]    tquo;
  logic [tmts_pkg::NumW-1:0]    squo;
  logic                         time_clip;
  logic                         samp_clip;

  assign in_accept = in_valid && !in_stall;
  assign load_acc  = in_accept && (action == tmts_pkg::ACT_LOAD);
  assign conv_acc  = in_accept && (action == tmts_pkg::ACT_CONVERT);
  assign tpb_eff   = (ticks_per_beat == '0) ? tmts_pkg::TpbW'(1) : ticks_per_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_beat <= tmts_pkg::TpbReset;
      sample_rate    <= tmts_pkg::RateReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tmts_pkg::REG_TPB:  ticks_per_beat <= cfg_data[tmts_pkg::TpbW-1:0];
        tmts_pkg::REG_RATE: sample_rate    <= cfg_data;
        default:            ticks_per_beat <= ticks_per_beat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else if (load_acc && last_segment) begin
      seg_count <= tmts_pkg::CountW'(segment_index) + 1'b1;
    end
  end

  // Launch register feeding the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_launch.valid <= 1'b0;
    end else begin
      tok_launch.valid <= conv_acc;
    end
    tok_launch.done <= (seg_count == '0);
    tok_launch.tick <= query_tick;
    tok_launch.acc  <= '0;
    tok_launch.prod <= '0;
  end

  assign tok[0] = tok_launch;

  for (genvar i = 0; i < tmts_pkg::MaxSegments; i++) begin : g_cell
    logic [tmts_pkg::TickW-1:0] nxt;
    logic                       last_here;
    if (i == tmts_pkg::MaxSegments - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = starts[i+1];
    end
    assign last_here     = (tmts_pkg::CountW'(i + 1) >= seg_count);
    assign tok_valids[i] = tok[i+1].valid;

    tmts_seg_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (load_acc && (segment_index == tmts_pkg::SegIdxW'(i))),
      .wr_start   (segment_start_tick),
      .wr_tempo   (segment_usec_per_beat),
      .is_last    (last_here),
      .next_start (nxt),
      .start_out  (starts[i]),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmts_pkg::S_IDLE: if (conv_acc) state_next = tmts_pkg::S_WALK;
      tmts_pkg::S_WALK: if (tok[tmts_pkg::MaxSegments].valid) state_next = tmts_pkg::S_MUL;
      tmts_pkg::S_MUL:  if (mul_cnt == MulLast) state_next = tmts_pkg::S_DIV;
      tmts_pkg::S_DIV:  if (tdiv_done) state_next = tmts_pkg::S_DONE;
      tmts_pkg::S_DONE: if (!out_valid || !out_stall) state_next = tmts_pkg::S_IDLE;
      default:          state_next = tmts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != tmts_pkg::S_IDLE);
    sum_load  = (state == tmts_pkg::S_WALK) && tok[tmts_pkg::MaxSegments].valid;
    div_start = (state == tmts_pkg::S_MUL) && (mul_cnt == MulLast);
    out_load  = (state == tmts_pkg::S_DONE) && (!out_valid || !out_stall);
  end

  // Shift-add multiply of the tempo-weighted tick sum by the sample rate, one rate bit a cycle.
  assign mprod_next = mprod + (mplier[0] ? mcand : '0);

  always_ff @(posedge clk) begin
    if (sum_load) begin
      sum     <= tok[tmts_pkg::MaxSegments].acc +
                 tmts_pkg::SumW'(tok[tmts_pkg::MaxSegments].prod);
      mcand   <= tmts_pkg::NumW'(tok[tmts_pkg::MaxSegments].acc +
                 tmts_pkg::SumW'(tok[tmts_pkg::MaxSegments].prod));
      mplier  <= sample_rate;
      mprod   <= '0;
      mul_cnt <= '0;
      den     <= tmts_pkg::DenW'(tpb_eff) * tmts_pkg::DenW'(tmts_pkg::UsecPerSec);
    end else if (state == tmts_pkg::S_MUL) begin
      mprod   <= mprod_next;
      mcand   <= {mcand[tmts_pkg::NumW-2:0], 1'b0};
      mplier  <= {1'b0, mplier[tmts_pkg::RateW-1:1]};
      mul_cnt <= mul_cnt + 1'b1;
    end
  end

  tmts_div u_tdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (tmts_pkg::NumW'(sum)),
    .den   (tmts_pkg::DenW'(tpb_eff)),
    .done  (tdiv_done),
    .quo   (tquo)
  );

  tmts_div u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mprod_next),
    .den   (den),
    .done  (sdiv_done),
    .quo   (squo)
  );

  assign time_clip = (tquo[tmts_pkg::NumW-1:tmts_pkg::TimeW] != '0);
  assign samp_clip = (squo[tmts_pkg::NumW-1:tmts_pkg::SampleW] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      time_usec     <= time_clip ? '1 : tquo[tmts_pkg::TimeW-1:0];
      sample_offset <= samp_clip ? '1 : squo[tmts_pkg::SampleW-1:0];
      saturated     <= time_clip || samp_clip;
    end
  end

  `TMTS_ASSERT(a_one_token, $onehot0(tok_valids))
  `TMTS_ASSERT(a_token_walk, tok[tmts_pkg::MaxSegments].valid |-> (state == tmts_pkg::S_WALK))
  `TMTS_ASSERT(a_div_lockstep, tdiv_done == sdiv_done)
  `TMTS_ASSERT_NEXT(a_conv_walk, conv_acc, state == tmts_pkg::S_WALK)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam logic [63:0] TimeMax   = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] SampleMax = 64'hFFFF_FFFF;
  localparam int          Settle    = 150;

  typedef struct {
    tmts_pkg::action_t act;
    logic [3:0]   idx;
    logic [31:0]  start;
    logic [23:0]  tempo;
    logic         last;
    logic [31:0]  tick;
    bit           drain;
  } tempo_item_t;

  typedef struct {
    logic [39:0] usec;
    logic [31:0] samples;
    logic        sat;
  } tick_time_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [3:0]  segment_index;
  logic [31:0] segment_start_tick;
  logic [23:0] segment_usec_per_beat;
  logic        last_segment;
  logic [31:0] query_tick;
  logic        out_valid;
  logic        out_stall;
  logic [39:0] time_usec;
  logic [31:0] sample_offset;
  logic        saturated;
  logic        cfg_write;
  logic        cfg_index;
  logic [17:0] cfg_data;

  tempo_map_tick_to_sample dut (.*);

  // Testbench copy of the tempo map and the timing registers.
  logic [31:0] map_start [16];
  logic [23:0] map_tempo [16];
  logic [4:0]  map_count;
  logic [15:0] beat_ticks;
  logic [17:0] rate_hz;

  tempo_item_t pending_items[$];
  tick_time_t  expected_times[$];
  tempo_item_t cur_item;
  bit          slot_loaded [16];
  int          snd_idle;
  int          rcv_idle;
  int          errors;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [63:0] add_clamp(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] tick_span(logic [31:0] from, logic [31:0] to);
    return (to > from) ? 64'(to - from) : 64'd0;
  endfunction

  function automatic tick_time_t tick_to_time(logic [31:0] tick);
    tick_time_t   res;
    logic [63:0]  acc, tpb, q, r, scaled, extra;
    logic [127:0] wide;
    int           n;
    bit           stop;
    acc = 0;
    stop = 0;
    n = map_count;
    for (int i = 0; i < n; i++) begin
      if (!stop) begin
        if (i + 1 >= n || map_start[i+1] > tick) begin
          acc = add_clamp(acc, 64'(map_tempo[i]) * tick_span(map_start[i], tick));
          stop = 1;
        end else begin
          acc = add_clamp(acc, 64'(map_tempo[i]) * tick_span(map_start[i], map_start[i+1]));
        end
      end
    end
    tpb = (beat_ticks == 0) ? 64'd1 : 64'(beat_ticks);
    q = acc / tpb;
    r = acc % tpb;
    res.sat = 1'b0;
    if (q > TimeMax) begin
      res.usec = '1;
      res.sat = 1'b1;
    end else begin
      res.usec = q[39:0];
    end
    if (rate_hz == 0) begin
      res.samples = 0;
    end else begin
      wide = 128'(q) * 128'(rate_hz);
      if (wide[127:64] != 0) begin
        res.samples = '1;
        res.sat = 1'b1;
      end else begin
        extra = (r * 64'(rate_hz)) / tpb;
        scaled = add_clamp(wide[63:0], extra) / 64'd1000000;
        if (scaled > SampleMax) begin
          res.samples = '1;
          res.sat = 1'b1;
        end else begin
          res.samples = scaled[31:0];
        end
      end
    end
    return res;
  endfunction

  function automatic void queue_load(logic [3:0] idx, logic [31:0] start, logic [23:0] tempo,
                                     logic last);
    tempo_item_t it;
    it.act = tmts_pkg::ACT_LOAD;
    it.idx = idx;
    it.start = start;
    it.tempo = tempo;
    it.last = last;
    it.tick = $urandom;
    it.drain = 0;
    slot_loaded[idx] = 1;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_convert(logic [31:0] tick, bit drain);
    tempo_item_t it;
    it.act = tmts_pkg::ACT_CONVERT;
    it.idx = 4'($urandom);
    it.start = $urandom;
    it.tempo = 24'($urandom);
    it.last = 1'($urandom);
    it.tick = tick;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  function automatic logic [23:0] pick_tempo();
    case ($urandom_range(9))
      0: return 24'hFF_FFFF;
      1: return 24'd0;
      default: return 24'($urandom_range(200000, 1500000));
    endcase
  endfunction

  // A sorted map with random content, then a few conversions around it.
  function automatic void queue_map_sequence();
    int          n;
    logic [31:0] start, step;
    n = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    case ($urandom_range(2))
      0: step = 2000;
      1: step = 32'd1 << 20;
      default: step = 32'd1 << 28;
    endcase
    start = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 500);
    for (int i = 0; i < n; i++) begin
      queue_load(4'(i), start, pick_tempo(), i == n - 1);
      start += $urandom_range(0, step);
    end
    repeat ($urandom_range(2, 5)) begin
      if ($urandom_range(4) == 0)
        queue_convert($urandom, 0);
      else
        queue_convert(start + $urandom_range(0, 2 * step) - step, 0);
    end
  endfunction

  // Loose loads into any slot; the count moves only onto fully loaded prefixes.
  function automatic void queue_noise();
    logic [3:0] idx;
    bit         ok;
    idx = 4'($urandom);
    ok = 1;
    for (int i = 0; i < idx; i++)
      if (!slot_loaded[i]) ok = 0;
    queue_load(idx, $urandom, 24'($urandom), ok && $urandom_range(1));
    queue_convert($urandom, 0);
  endfunction

  task automatic wait_quiet();
    while (pending_items.size() != 0 || expected_times.size() != 0 || in_valid)
      @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(tmts_pkg::cfg_reg_t idx, logic [17:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == tmts_pkg::REG_TPB)
      beat_ticks = value[15:0];
    else
      rate_hz = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_item.act == tmts_pkg::ACT_LOAD) begin
          map_start[cur_item.idx] = cur_item.start;
          map_tempo[cur_item.idx] = cur_item.tempo;
          if (cur_item.last)
            map_count = 5'(cur_item.idx) + 5'd1;
        end else begin
          expected_times.push_back(tick_to_time(cur_item.tick));
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle &&
            !(pending_items[0].drain && expected_times.size() != 0)) begin
          cur_item = pending_items.pop_front();
          action <= cur_item.act;
          segment_index <= cur_item.idx;
          segment_start_tick <= cur_item.start;
          segment_usec_per_beat <= cur_item.tempo;
          last_segment <= cur_item.last;
          query_tick <= cur_item.tick;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_times.size() == 0) begin
          $display("%0t: unexpected result time_usec=%0d sample_offset=%0d saturated=%0d",
                   $time, time_usec, sample_offset, saturated);
          errors++;
        end else begin
          tick_time_t want;
          want = expected_times.pop_front();
          if (time_usec !== want.usec) begin
            $display("%0t: time_usec expected %0d actual %0d", $time, want.usec, time_usec);
            errors++;
          end
          if (sample_offset !== want.samples) begin
            $display("%0t: sample_offset expected %0d actual %0d", $time, want.samples,
                     sample_offset);
            errors++;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %0d actual %0d", $time, want.sat, saturated);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  initial begin
    logic [17:0] tpb_set [6];
    logic [17:0] rate_set [6];
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    action = 1'b0;
    segment_index = '0;
    segment_start_tick = '0;
    segment_usec_per_beat = '0;
    last_segment = 1'b0;
    query_tick = '0;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    errors = 0;
    map_count = 0;
    beat_ticks = 16'd480;
    rate_hz = 18'd44100;
    snd_idle = 18;
    rcv_idle = 74;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty map, ticks before and inside one segment, unsorted starts,
    // extreme ticks and tempos, and a full sixteen-entry map that saturates.
    queue_convert(32'd1234, 0);
    queue_load(4'd0, 32'd100, 24'd500000, 1'b1);
    queue_convert(32'd0, 0);
    queue_convert(32'd100, 0);
    queue_convert(32'd1060, 0);
    queue_convert(32'hFFFF_FFFF, 0);
    queue_load(4'd1, 32'd50, 24'hFF_FFFF, 1'b1);
    queue_convert(32'd75, 0);
    queue_convert(32'hFFFF_FFFF, 0);
    queue_load(4'd1, 32'd2000, 24'd0, 1'b0);
    queue_convert(32'd5000, 1);
    for (int i = 2; i < 16; i++)
      queue_load(4'(i), 32'hFFFF_FFFF, 24'hFF_FFFF, i == 15);
    queue_load(4'd0, 32'd0, 24'hFF_FFFF, 1'b0);
    queue_load(4'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
    queue_convert(32'hFFFF_FFFF, 0);
    queue_convert(32'hFFFF_FFFE, 0);
    wait_quiet();

    tpb_set = '{18'd1, 18'd65535, 18'd0, 18'd96, 18'($urandom_range(1, 65535)), 18'd480};
    rate_set = '{18'd262143, 18'd1, 18'd0, 18'd48000, 18'($urandom_range(1, 262143)),
                 18'd44100};
    for (int c = 0; c < 6; c++) begin
      write_reg(tmts_pkg::REG_TPB, tpb_set[c]);
      write_reg(tmts_pkg::REG_RATE, rate_set[c]);
      snd_idle = (c < 2) ? 18 : (c < 4) ? 74 : 0;
      rcv_idle = (c < 2) ? 74 : (c < 4) ? 18 : 0;
      while (pending_items.size() < 88) begin
        if ($urandom_range(4) == 0)
          queue_noise();
        else
          queue_map_sequence();
      end
      queue_convert($urandom, 1);
      wait_quiet();
    end

    if (errors == 0)
      $display("tempo_map_tick_to_sample regression: pass");
    else
      $display("tempo_map_tick_to_sample regression: fail");
    $finish;
  end

  initial begin
    #3ms;
    $display("tempo_map_tick_to_sample regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tmts_pkg.sv
rtl/core/tmts_seg_cell.sv
rtl/core/tmts_div.sv
rtl/core/tempo_map_tick_to_sample.sv
tb/sv/tb_top.sv
